// ===== rtl/core/ssfr_pkg.sv =====
// Shared types and constants for the sensor supply fault retry block.
`default_nettype none
package ssfr_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = 3;
	localparam int MASK_W   = 8;
	localparam int MV_W     = 16;
	localparam int CNT_W    = 8;
	localparam int REG_IDX_W = 2;
	localparam int REG_DATA_W = 16;

	localparam logic [MASK_W-1:0] DISABLE_RST = 8'h00;
	localparam logic [MV_W-1:0]   MIN_DIFF_RST = 16'h0000;
	localparam logic [CNT_W-1:0]  OFF_WAIT_RST = 8'd55;
	localparam logic [CNT_W-1:0]  PROBE_WAIT_RST = 8'd5;
	localparam logic [MASK_W-1:0] OFF_RST   = 8'hFF;
	localparam logic [MASK_W-1:0] FAULT_RST = 8'hFF;
	localparam int CNT_RST_OFS = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DISABLE_MASK = 2'd0,
		REG_MIN_DIFF     = 2'd1,
		REG_OFF_WAIT     = 2'd2,
		REG_PROBE_WAIT   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [MASK_W-1:0]      disable_mask;
		logic signed [MV_W-1:0] min_diff;
		logic [CNT_W-1:0]       off_wait;
		logic [CNT_W-1:0]       probe_wait;
	} cfg_t;

	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic [MV_W-1:0] pos_mv;
		logic [MV_W-1:0] neg_mv;
		logic [MV_W-1:0] supply_mv;
	} meas_t;

	typedef struct packed {
		logic              cnt_we;
		logic [CNT_W-1:0]  cnt_nxt;
		logic [MASK_W-1:0] off_nxt;
		logic [MASK_W-1:0] fault_nxt;
	} upd_t;

	typedef struct packed {
		logic [CH_W-1:0]   out_channel;
		logic              channel_on;
		logic              channel_fault;
		logic [MASK_W-1:0] drive_mask;
		logic [MASK_W-1:0] fault_mask;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssfr_if.sv =====
// Valid/ready channel interfaces for measurements and results.
`default_nettype none
interface ssfr_meas_if import ssfr_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] channel;
	logic [MV_W-1:0] pos_mv;
	logic [MV_W-1:0] neg_mv;
	logic [MV_W-1:0] supply_mv;

	modport source (output valid, output channel, output pos_mv, output neg_mv,
		output supply_mv, input ready);
	modport sink (input valid, input channel, input pos_mv, input neg_mv,
		input supply_mv, output ready);
endinterface

interface ssfr_res_if import ssfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CH_W-1:0]   out_channel;
	logic              channel_on;
	logic              channel_fault;
	logic [MASK_W-1:0] drive_mask;
	logic [MASK_W-1:0] fault_mask;

	modport source (output valid, output out_channel, output channel_on,
		output channel_fault, output drive_mask, output fault_mask, input ready);
	modport sink (input valid, input out_channel, input channel_on,
		input channel_fault, input drive_mask, input fault_mask, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ssfr_cfg.sv =====
// Configuration register file with plain write port.
`default_nettype none
module ssfr_cfg import ssfr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire logic [REG_IDX_W-1:0]  wr_index,
	input  wire logic [REG_DATA_W-1:0] wr_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.disable_mask <= DISABLE_RST;
			cfg_q.min_diff     <= MIN_DIFF_RST;
			cfg_q.off_wait     <= OFF_WAIT_RST;
			cfg_q.probe_wait   <= PROBE_WAIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_DISABLE_MASK: cfg_q.disable_mask <= wr_data[MASK_W-1:0];
				REG_MIN_DIFF:     cfg_q.min_diff     <= wr_data[MV_W-1:0];
				REG_OFF_WAIT:     cfg_q.off_wait     <= wr_data[CNT_W-1:0];
				REG_PROBE_WAIT:   cfg_q.probe_wait   <= wr_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/ssfr_eval.sv =====
// Fault detection and hiccup retry decision for one channel measurement.
`default_nettype none
module ssfr_eval import ssfr_pkg::*; (
	input  meas_t                   meas,
	input  cfg_t                    cfg,
	input  wire logic [MASK_W-1:0]  off_cur,
	input  wire logic [MASK_W-1:0]  fault_cur,
	input  wire logic [CNT_W-1:0]   cnt_cur,
	output upd_t                    upd,
	output res_t                    res
);

	logic                ch_ok;
	logic [MASK_W-1:0]   bit_sel;
	logic [MV_W:0]       pos_x2;
	logic signed [MV_W:0] diff;
	logic                fault;

	always_comb begin
		ch_ok   = int'(meas.channel) < CHANNELS;
		bit_sel = MASK_W'(1) << meas.channel;
		pos_x2  = {meas.pos_mv, 1'b0};
		diff    = $signed({1'b0, meas.pos_mv}) - $signed({1'b0, meas.neg_mv});
		// pos < supply/2, or rail spread below the minimum
		fault   = (pos_x2 < {1'b0, meas.supply_mv}) ||
			(diff < $signed({cfg.min_diff[MV_W-1], cfg.min_diff}));

		upd.cnt_we    = 1'b0;
		upd.cnt_nxt   = cnt_cur;
		upd.off_nxt   = off_cur;
		upd.fault_nxt = fault_cur;

		if (ch_ok) begin
			upd.cnt_we = 1'b1;
			if (|(cfg.disable_mask & bit_sel)) begin
				upd.off_nxt   = off_cur | bit_sel;
				upd.fault_nxt = fault_cur | bit_sel;
				upd.cnt_nxt   = cfg.probe_wait;
			end else if (fault) begin
				if (cnt_cur == '0) begin
					if (!(|(off_cur & bit_sel))) begin
						upd.off_nxt   = off_cur | bit_sel;
						upd.fault_nxt = fault_cur | bit_sel;
						upd.cnt_nxt   = cfg.off_wait;
					end else begin
						// retry: switch back on, flag stays until a clean tick
						upd.off_nxt = off_cur & ~bit_sel;
						upd.cnt_nxt = cfg.probe_wait;
					end
				end else begin
					upd.cnt_nxt = cnt_cur - CNT_W'(1);
				end
			end else begin
				upd.cnt_nxt   = cfg.probe_wait;
				upd.fault_nxt = fault_cur & ~bit_sel;
			end
		end

		res.out_channel   = meas.channel;
		res.channel_on    = ch_ok && !(|(upd.off_nxt & bit_sel));
		res.channel_fault = ch_ok && (|(upd.fault_nxt & bit_sel));
		res.drive_mask    = ~upd.off_nxt;
		res.fault_mask    = upd.fault_nxt;
	end

endmodule
`default_nettype wire

// ===== rtl/core/sensor_supply_fault_retry_core.sv =====
// A measurement transaction passes through the input register, then the result
// register, which holds the evaluated channel state and drives result valid.
// Throughput: one measurement per cycle unless result.ready stalls the output; channel
// state is updated as the result is registered, so the next item sees it with no bubble.
// Reset: all channels off and faulty, countdown of channel i is i+2, registers
// at their defaults (disable 0, min_diff 0, off_wait 55, probe_wait 5).
`default_nettype none
module sensor_supply_fault_retry_core import ssfr_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	ssfr_meas_if.sink                  meas,
	ssfr_res_if.source                 result,
	input  wire logic                  wr_en,
	input  wire logic [REG_IDX_W-1:0]  wr_index,
	input  wire logic [REG_DATA_W-1:0] wr_data
);

	cfg_t              cfg;
	meas_t             meas_s1;
	logic              valid_s1;
	logic              out_valid_q;
	res_t              res_q;
	logic [MASK_W-1:0] off_q;
	logic [MASK_W-1:0] fault_q;
	logic [CNT_W-1:0]  cnt_q [MASK_W];
	upd_t              upd;
	res_t              res;
	logic              advance;
	logic              take;

	ssfr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	ssfr_eval u_eval (
		.meas      (meas_s1),
		.cfg       (cfg),
		.off_cur   (off_q),
		.fault_cur (fault_q),
		.cnt_cur   (cnt_q[meas_s1.channel]),
		.upd       (upd),
		.res       (res)
	);

	assign advance    = !out_valid_q || result.ready;
	assign meas.ready = !valid_s1 || advance;
	assign take       = meas.valid && meas.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (meas.ready) begin
			valid_s1 <= meas.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			meas_s1.channel   <= meas.channel;
			meas_s1.pos_mv    <= meas.pos_mv;
			meas_s1.neg_mv    <= meas.neg_mv;
			meas_s1.supply_mv <= meas.supply_mv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= OFF_RST;
			fault_q <= FAULT_RST;
			for (int i = 0; i < MASK_W; i++) begin
				cnt_q[i] <= CNT_W'(i + CNT_RST_OFS);
			end
		end else if (valid_s1 && advance) begin
			off_q   <= upd.off_nxt;
			fault_q <= upd.fault_nxt;
			if (upd.cnt_we) begin
				cnt_q[meas_s1.channel] <= upd.cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_channel   = res_q.out_channel;
	assign result.channel_on    = res_q.channel_on;
	assign result.channel_fault = res_q.channel_fault;
	assign result.drive_mask    = res_q.drive_mask;
	assign result.fault_mask    = res_q.fault_mask;

endmodule
`default_nettype wire
